>>> src/fasta_fastq_record_parser_assert.svh
// assertion macros for the record parser
`ifndef FASTA_FASTQ_RECORD_PARSER_ASSERT_SVH
`define FASTA_FASTQ_RECORD_PARSER_ASSERT_SVH
// property that must hold on every clock while out of reset
`define FFRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication checked on the next clock
`define FFRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> src/ffrp_pkg.sv
// shared types and constants for the record parser
package ffrp_pkg;
  localparam int unsigned NameCountBits = 16;
  localparam int unsigned SeqCountBits  = 32;
  localparam int unsigned QueueDepth    = 4;

  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_BASE = 2'd1,
    KIND_QUAL = 2'd2,
    KIND_END  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    CLS_NONE   = 4'd0,
    CLS_NAME   = 4'd1,
    CLS_BASE   = 4'd2,
    CLS_QUAL   = 4'd3,
    CLS_END_OK = 4'd4,
    CLS_END_FL = 4'd5,
    CLS_FA_RESTART = 4'd6,
    CLS_SEEK_START = 4'd7,
    CLS_SEEK_JUNK  = 4'd8,
    CLS_SEEK_CLEAR = 4'd9
  } cls_e;

  typedef enum logic [9:0] {
    PH_SEEK       = 10'b0000000001,
    PH_FA_NAME    = 10'b0000000010,
    PH_FA_SEQ     = 10'b0000000100,
    PH_FQ_NAME    = 10'b0000001000,
    PH_FQ_PRESEQ  = 10'b0000010000,
    PH_FQ_SEQ     = 10'b0000100000,
    PH_FQ_PREPLUS = 10'b0001000000,
    PH_FQ_PLUS    = 10'b0010000000,
    PH_FQ_PREQUAL = 10'b0100000000,
    PH_FQ_QUAL    = 10'b1000000000
  } phase_e;

  // classified byte handed from front to back
  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
    logic       ws;
    logic       fastq_start;
  } op_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == ChSpace) || (c >= 8'h09 && c <= ChCr);
  endfunction
endpackage

>>> src/ffrp_front.sv
// front: phase machine that classifies each input byte
module ffrp_front import ffrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output logic       op_valid_o,
  output op_t        op_o
);
  phase_e     phase_q, phase_d;
  logic [7:0] c;
  logic       ws, eoi, rec;

  assign c   = data_byte_i;
  assign ws  = is_ws(c);
  assign eoi = end_of_input_i || (c == 8'h00);
  assign rec = (c == ChGt) || (c == ChAt);

  always_comb begin
    phase_d        = phase_q;
    op_o.cls       = CLS_NONE;
    op_o.ch        = c;
    op_o.ws        = ws;
    op_o.fastq_start = (c == ChAt);
    if (eoi) begin
      phase_d = PH_SEEK;
      case (phase_q)
        PH_SEEK: op_o.cls = CLS_SEEK_CLEAR;
        PH_FQ_NAME, PH_FQ_PRESEQ, PH_FQ_SEQ, PH_FQ_PREPLUS: op_o.cls = CLS_END_FL;
        default: op_o.cls = CLS_END_OK;
      endcase
      op_o.ws = 1'b1;
    end else begin
      case (phase_q)
        PH_FA_NAME, PH_FQ_NAME: begin
          if (c == ChLf) begin
            phase_d = (phase_q == PH_FA_NAME) ? PH_FA_SEQ : PH_FQ_PRESEQ;
          end else if (c != ChCr) begin
            op_o.cls = CLS_NAME;
          end
        end
        PH_FA_SEQ: begin
          if (rec) begin
            op_o.cls = CLS_FA_RESTART;
            phase_d  = (c == ChGt) ? PH_FA_NAME : PH_FQ_NAME;
          end else if (!ws) begin
            op_o.cls = CLS_BASE;
          end
        end
        PH_FQ_PRESEQ, PH_FQ_SEQ: begin
          if (phase_q == PH_FQ_SEQ && c == ChLf) begin
            phase_d = PH_FQ_PREPLUS;
          end else if (!ws) begin
            phase_d  = PH_FQ_SEQ;
            op_o.cls = CLS_BASE;
          end
        end
        PH_FQ_PREPLUS: begin
          if (!ws) begin
            if (c == ChPlus) begin
              phase_d = PH_FQ_PLUS;
            end else begin
              phase_d  = PH_SEEK;
              op_o.cls = CLS_END_FL;
            end
          end
        end
        PH_FQ_PLUS: begin
          if (c == ChLf) phase_d = PH_FQ_PREQUAL;
        end
        PH_FQ_PREQUAL, PH_FQ_QUAL: begin
          if (phase_q == PH_FQ_QUAL && c == ChLf) begin
            phase_d  = PH_SEEK;
            op_o.cls = CLS_END_OK;
          end else if (!ws) begin
            phase_d  = PH_FQ_QUAL;
            op_o.cls = CLS_QUAL;
          end
        end
        default: begin
          phase_d = PH_SEEK;
          if (rec) begin
            phase_d  = (c == ChGt) ? PH_FA_NAME : PH_FQ_NAME;
            op_o.cls = CLS_SEEK_START;
          end else if (!ws) begin
            op_o.cls = CLS_SEEK_JUNK;
          end
        end
      endcase
    end
  end

  // seek bytes still go to the back so it can track resync
  assign op_valid_o = valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
    end else if (valid_i) begin
      phase_q <= phase_d;
    end
  end

  `include "fasta_fastq_record_parser_assert.svh"
  `FFRP_ASSERT(a_phase_onehot, $onehot(phase_q), "phase not one-hot")
  `FFRP_ASSERT_NEXT(a_eoi_seek, valid_i && eoi, phase_q == PH_SEEK, "eoi did not reset phase")
  `FFRP_ASSERT_NEXT(a_hold, !valid_i, $stable(phase_q), "phase moved without input")
endmodule

>>> src/ffrp_queue.sv
// short queue of classified bytes between front and back
module ffrp_queue import ffrp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  op_t  wdata_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output op_t  rdata_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  op_t           mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_i && !full_o) - (AW+1)'(rd_i && !empty_o);
    end
  end
endmodule

>>> src/ffrp_back.sv
// back: counters, flags and the result register
module ffrp_back import ffrp_pkg::*; #(
  parameter int unsigned NameBits = NameCountBits,
  parameter int unsigned SeqBits  = SeqCountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_empty_i,
  input  op_t         op_i,
  output logic        op_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] name_length_o,
  output logic [31:0] seq_length_o,
  output logic [31:0] qual_length_o,
  output logic        is_fastq_o,
  output logic        load_failed_o,
  output logic        resynced_o
);
  logic [NameBits-1:0] name_q, trim_q;
  logic [SeqBits-1:0]  base_q, qual_q;
  logic                fq_q, rs_q;
  logic                out_v_q;
  logic                emits, take, slot_free;
  logic [NameBits-1:0] name_inc;

  function automatic logic [15:0] clamp16(logic [NameBits-1:0] v);
    logic [NameBits+15:0] w;
    w = {16'h0, v};
    return (w > (NameBits+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [31:0] clamp32(logic [SeqBits-1:0] v);
    logic [SeqBits+31:0] w;
    w = {32'h0, v};
    return (w > (SeqBits+32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  assign emits     = (op_i.cls == CLS_NAME) || (op_i.cls == CLS_BASE) ||
                     (op_i.cls == CLS_QUAL) || (op_i.cls == CLS_END_OK) ||
                     (op_i.cls == CLS_END_FL) || (op_i.cls == CLS_FA_RESTART);
  assign slot_free = !out_v_q || pop;
  assign take      = !op_empty_i && (!emits || slot_free);
  assign op_pop_o  = take;
  assign empty     = !out_v_q;
  assign name_inc  = (&name_q) ? name_q : name_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (take && emits) begin
      kind_o        <= KIND_END;
      out_byte_o    <= 8'h00;
      name_length_o <= 16'h0;
      seq_length_o  <= 32'h0;
      qual_length_o <= 32'h0;
      is_fastq_o    <= 1'b0;
      load_failed_o <= 1'b0;
      resynced_o    <= 1'b0;
      case (op_i.cls)
        CLS_NAME: begin
          kind_o <= KIND_NAME; out_byte_o <= op_i.ch;
        end
        CLS_BASE: begin
          kind_o <= KIND_BASE; out_byte_o <= op_i.ch;
        end
        CLS_QUAL: begin
          kind_o <= KIND_QUAL; out_byte_o <= op_i.ch - ChBang;
        end
        CLS_END_FL: begin
          name_length_o <= clamp16(trim_q);
          is_fastq_o    <= fq_q;
          load_failed_o <= 1'b1;
          resynced_o    <= rs_q;
        end
        default: begin
          name_length_o <= clamp16(trim_q);
          seq_length_o  <= clamp32(base_q);
          qual_length_o <= clamp32(fq_q ? qual_q : base_q);
          is_fastq_o    <= fq_q;
          resynced_o    <= rs_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      name_q  <= '0;
      trim_q  <= '0;
      base_q  <= '0;
      qual_q  <= '0;
      fq_q    <= 1'b0;
      rs_q    <= 1'b0;
    end else begin
      if (take && emits) out_v_q <= 1'b1;
      else if (pop) out_v_q <= 1'b0;
      if (take) begin
        case (op_i.cls)
          CLS_NAME: begin
            name_q <= name_inc;
            if (!op_i.ws) trim_q <= name_inc;
          end
          CLS_BASE: base_q <= (&base_q) ? base_q : base_q + 1'b1;
          CLS_QUAL: qual_q <= (&qual_q) ? qual_q : qual_q + 1'b1;
          CLS_END_OK, CLS_END_FL, CLS_SEEK_CLEAR: begin
            name_q <= '0; trim_q <= '0; base_q <= '0; qual_q <= '0;
            fq_q <= 1'b0; rs_q <= 1'b0;
          end
          CLS_FA_RESTART: begin
            name_q <= '0; trim_q <= '0; base_q <= '0; qual_q <= '0;
            fq_q <= op_i.fastq_start; rs_q <= 1'b0;
          end
          CLS_SEEK_START: begin
            name_q <= '0; trim_q <= '0; base_q <= '0; qual_q <= '0;
            fq_q <= op_i.fastq_start;
          end
          CLS_SEEK_JUNK: rs_q <= 1'b1;
          default: begin
          end
        endcase
      end
    end
  end

  `include "fasta_fastq_record_parser_assert.svh"
  `FFRP_ASSERT_NEXT(a_pop_clears, pop && out_v_q && !(take && emits), empty,
    "result not retired")
  `FFRP_ASSERT_NEXT(a_hold_result, out_v_q && !pop, $stable(kind_o) && !empty,
    "stalled result changed")
  `FFRP_ASSERT(a_no_overwrite, !(take && emits && out_v_q && !pop), "result overwritten")
endmodule

>>> src/fasta_fastq_record_parser.sv
// FASTA/FASTQ record parser top level
// a byte that gives a result is written into the queue, then into the result register
// throughput: one byte per cycle while the queue is not full, set by the phase machine
// a stalled result stops the back at the next byte that gives a result; the front keeps going until the queue fills
// reset: asynchronous, active low; parser seeks a record start, counters cleared
// no result is shown while in reset
module fasta_fastq_record_parser import ffrp_pkg::*; #(
  parameter int unsigned NAME_COUNT_BITS = NameCountBits,
  parameter int unsigned SEQ_COUNT_BITS  = SeqCountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] name_length_o,
  output logic [31:0] seq_length_o,
  output logic [31:0] qual_length_o,
  output logic        is_fastq_o,
  output logic        load_failed_o,
  output logic        resynced_o
);
  logic op_valid, q_empty, q_pop;
  op_t  op_in, op_out;

  ffrp_front u_front (
    .clk_i, .rst_ni,
    .valid_i        (push && !full),
    .data_byte_i,
    .end_of_input_i,
    .op_valid_o     (op_valid),
    .op_o           (op_in)
  );

  ffrp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_i    (op_valid),
    .wdata_i (op_in),
    .full_o  (full),
    .rd_i    (q_pop),
    .empty_o (q_empty),
    .rdata_o (op_out)
  );

  ffrp_back #(.NameBits(NAME_COUNT_BITS), .SeqBits(SEQ_COUNT_BITS)) u_back (
    .clk_i, .rst_ni,
    .op_empty_i (q_empty),
    .op_i       (op_out),
    .op_pop_o   (q_pop),
    .empty, .pop,
    .kind_o, .out_byte_o, .name_length_o, .seq_length_o, .qual_length_o,
    .is_fastq_o, .load_failed_o, .resynced_o
  );
endmodule
